// File: design/tdc_code_density_calibrator_defines.svh
// ----------------------------------------------------------------------------
// tdc_code_density_calibrator_defines
// assertion macros used by the calibrator rtl
// ----------------------------------------------------------------------------
`ifndef TDC_CODE_DENSITY_CALIBRATOR_DEFINES_SVH
`define TDC_CODE_DENSITY_CALIBRATOR_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define TDC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define TDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tdc_cdc_pkg.sv
// ----------------------------------------------------------------------------
// tdc_cdc_pkg
// types and command codes of the tdc code-density calibrator
// ----------------------------------------------------------------------------
package tdc_cdc_pkg;

  localparam int unsigned OutW = 49;

  typedef enum logic [2:0] {
    CMD_ADD       = 3'd0,
    CMD_RECOMPUTE = 3'd1,
    CMD_CORRECT   = 3'd2,
    CMD_CLEAR     = 3'd3,
    CMD_SHIFT     = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_COR_RD,
    ST_COR_CALC,
    ST_COR_OUT,
    ST_RC_TOT,
    ST_RC_RD,
    ST_RC_ACC,
    ST_RC_DIV,
    ST_RC_WR,
    ST_RC_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [4:0]         channel;
    logic [31:0]        hit_time;
    logic               use_shift;
    logic signed [23:0] shift_value;
  } in_item_t;

  typedef struct packed {
    logic signed [OutW-1:0] corrected_time;
    logic                   result_kind;
  } out_item_t;

endpackage

// File: design/tdc_code_density_calibrator.sv
// ----------------------------------------------------------------------------
// tdc_code_density_calibrator
// per-channel code-density histogram, edge recompute and hit time correction
// ----------------------------------------------------------------------------
// Usage: drive item_i and raise start_i while busy_o is low; the command is
// transferred at that edge. Results appear on result_o for one cycle with
// result_valid_o high; the receiver cannot stall, so nothing waits.
// Add hit: read bin and total, write back; no result.
// Correct: the result follows the edge read for bin 0 and comes after an extra
// read of the lower edge otherwise.
// Set shift: taken at the transfer, busy_o stays low. Recompute: a bit-serial
// divider computes each edge of every nonempty channel, written through the
// single port of the edge memory; a result with result_kind 1 ends it.
// Clear: one histogram entry per cycle over all CHANNELS*BINS entries.
// After reset a clearing pass over all CHANNELS*BINS entries zeroes the counts
// and writes the linear edges (bin j gives j+1); busy_o is high meanwhile.
// Unused codes and channels at or above CHANNELS are dropped; busy_o stays low.
// ----------------------------------------------------------------------------
`include "tdc_code_density_calibrator_defines.svh"

module tdc_code_density_calibrator #(
  parameter int unsigned CHANNELS  = 32,
  parameter int unsigned FINE_BITS = 5,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  tdc_cdc_pkg::in_item_t  item_i,
  output logic                   busy_o,
  output logic                   result_valid_o,
  output tdc_cdc_pkg::out_item_t result_o
);
  import tdc_cdc_pkg::*;

  localparam int unsigned Bins   = 1 << FINE_BITS;
  localparam int unsigned ChW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned AddrW  = ChW + FINE_BITS;
  localparam int unsigned Depth  = CHANNELS * Bins;
  localparam int unsigned EdgeW  = FINE_BITS + FRAC_BITS + 1;
  localparam int unsigned DivN   = FINE_BITS + FRAC_BITS;
  localparam int unsigned DivCntW = $clog2(DivN + 1);
  localparam int unsigned SumW   = (FRAC_BITS + 34 > OutW + 1) ? FRAC_BITS + 34 : OutW + 1;
  localparam logic [31:0] SatMax = '1;
  localparam logic signed [OutW-1:0] OutMax = {1'b0, {(OutW-1){1'b1}}};
  localparam logic signed [OutW-1:0] OutMin = {1'b1, {(OutW-1){1'b0}}};

  logic [31:0]        cnt_mem  [Depth];
  logic [EdgeW-1:0]   edge_mem [Depth];
  logic [31:0]        tot_mem  [CHANNELS];
  logic signed [23:0] shift_q  [CHANNELS];

  state_e state_q, state_d;
  in_item_t item_q;
  logic [AddrW:0] idx_q, idx_d;
  logic [ChW:0] ch_q, ch_d;
  logic [FINE_BITS:0] bin_q, bin_d;
  logic [32:0] cum_q, cum_d;
  logic [31:0] total_q;
  logic [32:0] rem_q, rem_d;
  logic [EdgeW-1:0] quo_q, quo_d;
  logic [DivCntW-1:0] dcnt_q, dcnt_d;
  logic init_q, init_d;
  logic [SumW-1:0] sum_q;

  logic [AddrW-1:0] cnt_addr, edge_addr;
  logic cnt_we, edge_we;
  logic [31:0] cnt_wdata, cnt_rdata_q;
  logic [EdgeW-1:0] edge_wdata, edge_rdata_q;
  logic tot_we;
  logic [ChW-1:0] tot_addr;
  logic [31:0] tot_wdata;

  logic accept;
  logic ch_ok;
  logic [ChW-1:0] in_ch, item_ch;
  logic [FINE_BITS-1:0] fine;
  logic [AddrW-1:0] hit_addr;

  assign accept   = start_i && !busy_o;
  assign ch_ok    = (32'(item_i.channel) < CHANNELS);
  assign in_ch    = ChW'(item_i.channel);
  assign item_ch  = ChW'(item_q.channel);
  assign fine     = item_q.hit_time[FINE_BITS-1:0];
  assign hit_addr = {item_ch, fine};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(item_i.cmd))
            CMD_ADD:       if (ch_ok) state_d = ST_ADD_RD;
            CMD_CORRECT:   if (ch_ok) state_d = ST_COR_RD;
            CMD_CLEAR:     state_d = ST_CLEAR;
            CMD_RECOMPUTE: state_d = ST_RC_TOT;
            default:       state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR:    if (idx_q == (AddrW+1)'(Depth - 1)) state_d = ST_IDLE;
      ST_ADD_RD:   state_d = ST_ADD_WR;
      ST_ADD_WR:   state_d = ST_IDLE;
      ST_COR_RD:   state_d = (fine == '0) ? ST_COR_CALC : ST_COR_OUT;
      ST_COR_OUT:  state_d = ST_COR_CALC;
      ST_COR_CALC: state_d = ST_IDLE;
      ST_RC_TOT: begin
        if (ch_q == (ChW+1)'(CHANNELS)) state_d = ST_RC_DONE;
        else if (tot_mem[ch_q[ChW-1:0]] == '0) state_d = ST_RC_TOT;
        else state_d = ST_RC_RD;
      end
      ST_RC_RD:  state_d = ST_RC_ACC;
      ST_RC_ACC: state_d = ST_RC_DIV;
      ST_RC_DIV: if (dcnt_q == DivCntW'(DivN)) state_d = ST_RC_WR;
      ST_RC_WR:  state_d = (bin_q == (FINE_BITS+1)'(Bins - 1)) ? ST_RC_TOT : ST_RC_RD;
      ST_RC_DONE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    logic [33:0] r2;
    logic [32:0] csum;
    idx_d = idx_q;
    ch_d = ch_q;
    bin_d = bin_q;
    cum_d = cum_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dcnt_d = dcnt_q;
    init_d = init_q;
    cnt_we = 1'b0;
    cnt_addr = hit_addr;
    cnt_wdata = '0;
    edge_we = 1'b0;
    edge_addr = hit_addr;
    edge_wdata = '0;
    tot_we = 1'b0;
    tot_addr = item_ch;
    tot_wdata = '0;
    r2 = '0;
    csum = '0;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        ch_d = '0;
        init_d = 1'b0;
        edge_addr = {in_ch, item_i.hit_time[FINE_BITS-1:0]};
        if (accept && cmd_e'(item_i.cmd) == CMD_RECOMPUTE) ch_d = '0;
      end
      ST_CLEAR: begin
        cnt_we = 1'b1;
        cnt_addr = idx_q[AddrW-1:0];
        edge_we = init_q;
        edge_addr = idx_q[AddrW-1:0];
        edge_wdata = EdgeW'({1'b0, idx_q[FINE_BITS-1:0]} + (FINE_BITS+1)'(1)) << FRAC_BITS;
        if (idx_q[FINE_BITS-1:0] == '1) begin
          tot_we = 1'b1;
          tot_addr = idx_q[AddrW-1:FINE_BITS];
        end
        idx_d = idx_q + 1'b1;
      end
      ST_ADD_WR: begin
        cnt_we = 1'b1;
        cnt_wdata = (cnt_rdata_q == SatMax) ? SatMax : cnt_rdata_q + 32'd1;
        tot_we = 1'b1;
        tot_wdata = (tot_mem[tot_addr] == SatMax) ? SatMax : tot_mem[tot_addr] + 32'd1;
      end
      ST_COR_RD: begin
        edge_addr = hit_addr - AddrW'(1);
      end
      ST_RC_TOT: begin
        bin_d = '0;
        cum_d = '0;
        if (ch_q != (ChW+1)'(CHANNELS) && tot_mem[ch_q[ChW-1:0]] == '0) ch_d = ch_q + 1'b1;
      end
      ST_RC_RD: begin
        cnt_addr = {ch_q[ChW-1:0], bin_q[FINE_BITS-1:0]};
      end
      ST_RC_ACC: begin
        csum = cum_q + {1'b0, cnt_rdata_q};
        if (csum > {1'b0, total_q}) csum = {1'b0, total_q};
        cum_d = csum;
        rem_d = csum;
        quo_d = (csum == {1'b0, total_q}) ? EdgeW'(1) : '0;
        if (csum == {1'b0, total_q}) rem_d = '0;
        dcnt_d = '0;
      end
      ST_RC_DIV: begin
        r2 = {rem_q, 1'b0};
        if (r2 >= {2'b0, total_q}) begin
          rem_d = 33'(r2 - {2'b0, total_q});
          quo_d = {quo_q[EdgeW-2:0], 1'b1};
        end else begin
          rem_d = r2[32:0];
          quo_d = {quo_q[EdgeW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DivCntW'(DivN)) begin
          rem_d = rem_q;
          quo_d = quo_q;
        end
      end
      ST_RC_WR: begin
        edge_we = 1'b1;
        edge_addr = {ch_q[ChW-1:0], bin_q[FINE_BITS-1:0]};
        edge_wdata = quo_q;
        bin_d = bin_q + 1'b1;
        if (bin_q == (FINE_BITS+1)'(Bins - 1)) ch_d = ch_q + 1'b1;
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    logic [SumW-1:0] t;
    busy_o = (state_q != ST_IDLE);
    result_valid_o = (state_q == ST_RC_DONE) || (state_q == ST_COR_CALC);
    result_o = '0;
    t = sum_q;
    if (state_q == ST_RC_DONE) begin
      result_o.result_kind = 1'b1;
    end else begin
      if ($signed(t) > $signed(SumW'(OutMax))) result_o.corrected_time = OutMax;
      else if ($signed(t) < $signed(SumW'(OutMin)))
        result_o.corrected_time = OutMin;
      else result_o.corrected_time = t[OutW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_addr] <= cnt_wdata;
    cnt_rdata_q <= cnt_mem[cnt_addr];
    if (edge_we) edge_mem[edge_addr] <= edge_wdata;
    edge_rdata_q <= edge_mem[edge_addr];
    if (tot_we) tot_mem[tot_addr] <= tot_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= item_i;
    if (state_q == ST_RC_TOT && ch_q != (ChW+1)'(CHANNELS)) total_q <= tot_mem[ch_q[ChW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q <= '0;
      ch_q <= '0;
      bin_q <= '0;
      cum_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      dcnt_q <= '0;
      init_q <= 1'b1;
      for (int i = 0; i < CHANNELS; i++) shift_q[i] <= '0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      ch_q <= ch_d;
      bin_q <= bin_d;
      cum_q <= cum_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
      dcnt_q <= dcnt_d;
      init_q <= init_d;
      if (accept && cmd_e'(item_i.cmd) == CMD_SHIFT && ch_ok)
        shift_q[in_ch] <= item_i.shift_value;
    end
  end

  // hold the upper edge across the extra read of the lower edge
  logic [EdgeW-1:0] hi_edge_q;
  logic [SumW-1:0] sum_c;
  always_ff @(posedge clk_i) begin
    if (state_q == ST_COR_RD) hi_edge_q <= edge_rdata_q;
  end
  always_comb begin
    logic [EdgeW:0] mid;
    logic [EdgeW-1:0] lo, hi;
    lo = (fine == '0) ? '0 : edge_rdata_q;
    hi = (fine == '0) ? edge_rdata_q : hi_edge_q;
    mid = ({1'b0, lo} + {1'b0, hi}) >> 1;
    sum_c = (SumW'({item_q.hit_time[31:FINE_BITS], {FINE_BITS{1'b0}}}) << FRAC_BITS)
            + SumW'(mid);
    if (item_q.use_shift)
      sum_c = sum_c + SumW'(signed'(shift_q[item_ch]));
  end
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_COR_RD && fine == '0) || state_q == ST_COR_OUT) sum_q <= sum_c;
  end

  `TDC_ASSERT_IMP(a_single_result, clk_i, rst_ni, result_valid_o, busy_o,
    "result outside a command")
  `TDC_ASSERT_NEXT(a_busy_after_start, clk_i, rst_ni,
    accept && item_i.cmd == CMD_RECOMPUTE, busy_o, "recompute not started")
  `TDC_ASSERT_IMP(a_div_bound, clk_i, rst_ni, state_q == ST_RC_DIV,
    dcnt_q <= DivCntW'(DivN), "divider overran")

endmodule

// File: tb/tb_tdc_code_density_calibrator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tdc_code_density_calibrator
// checks the code-density calibrator against an in-bench histogram predictor
// ----------------------------------------------------------------------------
// Commands go through the start/busy handshake, mostly with random gaps. Every
// accepted command updates a predictor that keeps its own histograms, edges and
// shifts; every strobed result is compared with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_tdc_code_density_calibrator;
  import tdc_cdc_pkg::*;

  localparam int unsigned NumCh    = 32;
  localparam int unsigned NumBins  = 32;
  localparam int unsigned FineW    = 5;
  localparam int unsigned FracW    = 16;
  localparam int unsigned NumItems = 1250;
  localparam int unsigned StallMax = 100000;
  localparam logic [2:0]  CodeSpareLo = 3'd5;
  localparam logic [2:0]  CodeSpareHi = 3'd7;

  class calib_scoreboard;
    longint unsigned hist[NumCh][NumBins];
    longint unsigned totals[NumCh];
    longint unsigned edges[NumCh][NumBins];
    longint          shifts[NumCh];
    out_item_t       pending[$];
    int              errors;

    function new();
      errors = 0;
      for (int c = 0; c < NumCh; c++) begin
        totals[c] = 0;
        shifts[c] = 0;
        for (int j = 0; j < NumBins; j++) begin
          hist[c][j]  = 0;
          edges[c][j] = longint'(j + 1) << FracW;
        end
      end
    endfunction

    task report(string what);
      $display("ERROR at %0t: %s", $time, what);
      errors++;
    endtask

    function void rebuild_edges();
      longint unsigned cum;
      for (int c = 0; c < NumCh; c++) begin
        if (totals[c] != 0) begin
          cum = 0;
          for (int j = 0; j < NumBins; j++) begin
            cum += hist[c][j];
            if (cum > totals[c]) cum = totals[c];
            edges[c][j] = (cum << (FineW + FracW)) / totals[c];
          end
        end
      end
    endfunction

    function void note(in_item_t it);
      out_item_t       res;
      int unsigned     ch, f;
      longint unsigned lo, hi, coarse;
      longint          t;
      ch = 32'(it.channel);
      f  = 32'(it.hit_time[FineW-1:0]);
      case (it.cmd)
        CMD_ADD: begin
          if (hist[ch][f] != 64'hFFFF_FFFF) hist[ch][f]++;
          if (totals[ch] != 64'hFFFF_FFFF) totals[ch]++;
        end
        CMD_RECOMPUTE: begin
          rebuild_edges();
          res.corrected_time = '0;
          res.result_kind    = 1'b1;
          pending.push_back(res);
        end
        CMD_CLEAR: begin
          for (int c = 0; c < NumCh; c++) begin
            totals[c] = 0;
            for (int j = 0; j < NumBins; j++) hist[c][j] = 0;
          end
        end
        CMD_SHIFT: shifts[ch] = longint'(it.shift_value);
        CMD_CORRECT: begin
          coarse = longint'({it.hit_time[31:FineW], {FineW{1'b0}}}) << FracW;
          hi = edges[ch][f];
          lo = (f == 0) ? 0 : edges[ch][f-1];
          t  = longint'(coarse + ((lo + hi) >> 1));
          if (it.use_shift) t += shifts[ch];
          if (t > (64'sd1 <<< 48) - 1) t = (64'sd1 <<< 48) - 1;
          if (t < -(64'sd1 <<< 48)) t = -(64'sd1 <<< 48);
          res.corrected_time = t[OutW-1:0];
          res.result_kind    = 1'b0;
          pending.push_back(res);
        end
        default: ;
      endcase
    endfunction

    task check(out_item_t got);
      out_item_t exp_res;
      if (pending.size() == 0) begin
        report("result with nothing expected");
      end else begin
        exp_res = pending.pop_front();
        if (got.result_kind !== exp_res.result_kind)
          report($sformatf("result_kind %0b, expected %0b", got.result_kind,
                           exp_res.result_kind));
        if (got.corrected_time !== exp_res.corrected_time)
          report($sformatf("corrected_time %h, expected %h", got.corrected_time,
                           exp_res.corrected_time));
      end
    endtask
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  in_item_t  item_i = '0;
  logic      busy_o, result_valid_o;
  out_item_t result_o;

  calib_scoreboard sb = new();
  bit          gaps_on = 1'b1;
  int unsigned stall_cnt = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  tdc_code_density_calibrator u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note(item_i);
      if (result_valid_o) sb.check(result_o);
      if ((start_i && !busy_o) || result_valid_o) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt > StallMax) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task send(in_item_t it);
    while (gaps_on && $urandom_range(99) < 38) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
  endtask

  task send_cmd(logic [2:0] cmd, int unsigned ch, logic [31:0] hit,
                logic use_sh, logic [23:0] sh);
    in_item_t it;
    it.cmd         = cmd;
    it.channel     = ch[4:0];
    it.hit_time    = hit;
    it.use_shift   = use_sh;
    it.shift_value = sh;
    send(it);
  endtask

  task send_random();
    int unsigned pick, ch;
    logic [31:0] hit;
    pick = $urandom_range(999);
    ch   = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(3);
    hit  = $urandom();
    case ($urandom_range(9))
      0: hit = 32'hFFFF_FFFF;
      1: hit[31:12] = '0;
      2: hit[FineW-1:0] = FineW'($urandom_range(3));
      default: ;
    endcase
    if (pick < 12)       send_cmd(CMD_RECOMPUTE, ch, hit, 1'($urandom()), 24'($urandom()));
    else if (pick < 30)  send_cmd(CMD_CLEAR, ch, hit, 1'($urandom()), 24'($urandom()));
    else if (pick < 50)
      send_cmd(3'($urandom_range(CodeSpareLo, CodeSpareHi)), ch, hit, 1'($urandom()),
               24'($urandom()));
    else if (pick < 110) send_cmd(CMD_SHIFT, ch, hit, 1'($urandom()), 24'($urandom()));
    else if (pick < 420) send_cmd(CMD_CORRECT, ch, hit, 1'($urandom()), 24'($urandom()));
    else                 send_cmd(CMD_ADD, ch, hit, 1'($urandom()), 24'($urandom()));
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset edges, extremes of time and shift
    send_cmd(CMD_CORRECT, 0, 32'h0000_0000, 1'b0, 24'h0);
    send_cmd(CMD_CORRECT, 31, 32'hFFFF_FFFF, 1'b0, 24'h0);
    send_cmd(CMD_SHIFT, 1, 32'h0, 1'b0, 24'h7F_FFFF);
    send_cmd(CMD_SHIFT, 2, 32'h0, 1'b0, 24'h80_0000);
    send_cmd(CMD_CORRECT, 1, 32'hFFFF_FFFF, 1'b1, 24'h0);
    send_cmd(CMD_CORRECT, 2, 32'h0000_0000, 1'b1, 24'h0);
    send_cmd(CMD_CORRECT, 2, 32'h0000_0000, 1'b0, 24'h0);
    send_cmd(CodeSpareLo, 0, 32'h0, 1'b0, 24'h0);
    send_cmd(CodeSpareHi, 0, 32'hFFFF_FFFF, 1'b1, 24'hFF_FFFF);
    // skewed histogram on channel 0, channel 3 left empty
    for (int k = 0; k < 8; k++) send_cmd(CMD_ADD, 0, k % 3, 1'b0, 24'h0);
    send_cmd(CMD_ADD, 0, 32'hFFFF_FFFF, 1'b0, 24'h0);
    send_cmd(CMD_RECOMPUTE, 0, 32'h0, 1'b0, 24'h0);
    send_cmd(CMD_CORRECT, 0, 32'h0000_0001, 1'b0, 24'h0);
    send_cmd(CMD_CORRECT, 0, 32'h0000_001F, 1'b0, 24'h0);
    send_cmd(CMD_CORRECT, 3, 32'h0000_0005, 1'b0, 24'h0);
    send_cmd(CMD_CLEAR, 0, 32'h0, 1'b0, 24'h0);
    send_cmd(CMD_CORRECT, 0, 32'h0000_0002, 1'b0, 24'h0);
    for (int n = 0; n < NumItems; n++) begin
      gaps_on = !(n >= 400 && n < 700);
      send_random();
    end
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/tdc_cdc_pkg.sv
design/tdc_code_density_calibrator.sv
tb/tb_tdc_code_density_calibrator.sv
